### hdl/sre_pkg.sv
// Shared types and constants of the shortest-path relaxation engine.
`default_nettype none

package sre_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned OP_W       = 2;
  localparam int unsigned VTX_W      = 10;
  localparam int unsigned IN_DIST_W  = 32;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned IN_WT_W    = 16;
  localparam int unsigned IN_DEG_W   = 5;
  localparam int unsigned OUT_DIST_W = 32;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RELAX     = 2'd0,
    OP_WR_EDGE   = 2'd1,
    OP_WR_DEGREE = 2'd2,
    OP_RD_DIST   = 2'd3
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_DECIDE = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

endpackage : sre_pkg

`default_nettype wire

### hdl/sssp_relaxation_engine.sv
// Top level of the shortest-path relaxation engine: stores, sequencer and edge walk.
`default_nettype none

// Relaxation engine for chaotic-relaxation shortest paths. After reset the block
// runs a clearing pass over all NUM_VERTICES entries (busy high) that sets every
// distance to infinity and every degree to zero. A request is taken when start is
// high and busy is low. Write edge and write degree finish in S_EXEC and give no
// result. Read distance, a relax that does not improve and an improved relax of a
// vertex with no edges give one result, registered from S_DECIDE after the store
// read. An improved relax with edges gives its first message after S_EXEC, S_DECIDE
// and the first edge read, and then one message per cycle, one per edge, so it holds
// busy through S_EXEC, S_DECIDE and S_EMIT. The pace is set by the edge store, read
// one edge per cycle, and the single saturating adder behind it. Results appear on
// done_o for exactly one cycle each and cannot be held off; last_o marks the final
// result of a request, and busy drops in the cycle it is shown.
module sssp_relaxation_engine #(
  parameter int unsigned NUM_VERTICES = 1024,
  parameter int unsigned MAX_DEGREE   = 16,
  parameter int unsigned DIST_BITS    = 32,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [sre_pkg::OP_W-1:0]        operation_i,
  input  logic [sre_pkg::VTX_W-1:0]       vertex_i,
  input  logic [sre_pkg::IN_DIST_W-1:0]   tentative_distance_i,
  input  logic [sre_pkg::SLOT_W-1:0]      edge_slot_i,
  input  logic [sre_pkg::VTX_W-1:0]       edge_target_i,
  input  logic [sre_pkg::IN_WT_W-1:0]     edge_weight_i,
  input  logic [sre_pkg::IN_DEG_W-1:0]    degree_value_i,
  output logic                            done_o,
  output logic                            is_message_o,
  output logic                            improved_o,
  output logic [sre_pkg::VTX_W-1:0]       message_vertex_o,
  output logic [sre_pkg::OUT_DIST_W-1:0]  message_distance_o,
  output logic                            last_o
);
  import sre_pkg::*;

  localparam int unsigned VW         = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned SLW        = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned DGW        = $clog2(MAX_DEGREE + 1);
  localparam int unsigned EAW        = VW + SLW;
  localparam int unsigned EDGE_DEPTH = NUM_VERTICES << SLW;
  localparam int unsigned EW         = VTX_W + WEIGHT_BITS;
  localparam int unsigned SUMW       = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS
                                                                  : WEIGHT_BITS) + 1;
  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};
  localparam logic [VW-1:0]        LAST_VTX = VW'(NUM_VERTICES - 1);
  localparam logic [DGW-1:0]       DEG_MAX  = DGW'(MAX_DEGREE);

  // Storage
  logic [DIST_BITS-1:0] dist_mem [NUM_VERTICES];
  logic [DGW-1:0]       deg_mem  [NUM_VERTICES];
  logic [EW-1:0]        edge_mem [EDGE_DEPTH];

  // Sequencer and request registers
  state_e               state_q, state_d;
  logic [VW-1:0]        clr_q, clr_d;
  op_e                  op_q;
  logic [VTX_W-1:0]     vtx_q;
  logic                 vok_q;
  logic                 slot_ok_q;
  logic [SLW-1:0]       slot_q;
  logic [VTX_W-1:0]     tgt_q;
  logic [WEIGHT_BITS-1:0] wt_q;
  logic [DGW-1:0]       deg_in_q;
  logic [DIST_BITS-1:0] tent_q;
  logic [DGW-1:0]       rd_idx_q, rd_idx_d;
  logic [DGW-1:0]       emit_idx_q, emit_idx_d;

  // Memory ports
  logic                 dist_we, deg_we, edge_we;
  logic [VW-1:0]        dist_wa, rd_addr;
  logic [DIST_BITS-1:0] dist_wd;
  logic [DGW-1:0]       deg_wd;
  logic [DIST_BITS-1:0] dist_rd_q;
  logic [DGW-1:0]       deg_rd_q;
  logic [EW-1:0]        edge_rd_q;
  logic [EAW-1:0]       edge_wa, edge_ra;

  // Result registers
  logic                  done_q, done_d;
  logic                  is_msg_q, is_msg_d;
  logic                  impr_q, impr_d;
  logic [VTX_W-1:0]      mvtx_q, mvtx_d;
  logic [OUT_DIST_W-1:0] mdist_q, mdist_d;
  logic                  last_q, last_d;

  // Single saturating adder
  logic [SUMW-1:0]       sum_w, wt_ext, inf_ext, sat_sum;
  logic                  sat;
  logic                  accept;
  logic                  emit_last;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  assign wt_ext  = SUMW'(edge_rd_q[WEIGHT_BITS-1:0]);
  assign inf_ext = SUMW'(DIST_INF);
  assign sum_w   = SUMW'(tent_q) + wt_ext;
  assign sat     = (wt_ext <= inf_ext) && (sum_w > inf_ext);
  assign sat_sum = sat ? inf_ext : sum_w;

  assign emit_last = (emit_idx_q == (deg_rd_q - DGW'(1)));

  assign rd_addr = VW'(vtx_q);
  assign edge_wa = {VW'(vtx_q), slot_q};
  assign edge_ra = {VW'(vtx_q), rd_idx_q[SLW-1:0]};

  // Distance store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_q <= dist_mem[rd_addr];
  end

  // Degree store
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[dist_wa] <= deg_wd;
    end
    deg_rd_q <= deg_mem[rd_addr];
  end

  // Edge store: {target, weight}
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= {tgt_q, wt_q};
    end
    edge_rd_q <= edge_mem[edge_ra];
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_e'(operation_i);
      vtx_q     <= vertex_i;
      vok_q     <= (32'(vertex_i) < NUM_VERTICES);
      slot_ok_q <= (32'(edge_slot_i) < MAX_DEGREE);
      slot_q    <= SLW'(edge_slot_i);
      tgt_q     <= edge_target_i;
      wt_q      <= WEIGHT_BITS'(edge_weight_i);
      deg_in_q  <= (32'(degree_value_i) > MAX_DEGREE) ? DEG_MAX : DGW'(degree_value_i);
      tent_q    <= DIST_BITS'(tentative_distance_i);
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rd_idx_d   = rd_idx_q;
    emit_idx_d = emit_idx_q;
    dist_we    = 1'b0;
    deg_we     = 1'b0;
    edge_we    = 1'b0;
    dist_wa    = rd_addr;
    dist_wd    = tent_q;
    deg_wd     = deg_in_q;
    done_d     = 1'b0;
    is_msg_d   = 1'b0;
    impr_d     = 1'b0;
    mvtx_d     = '0;
    mdist_d    = '0;
    last_d     = 1'b1;

    unique case (state_q)
      S_CLEAR: begin
        dist_we = 1'b1;
        deg_we  = 1'b1;
        dist_wa = clr_q;
        dist_wd = DIST_INF;
        deg_wd  = '0;
        clr_d   = clr_q + VW'(1);
        if (clr_q == LAST_VTX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          rd_idx_d   = '0;
          emit_idx_d = '0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // loads finish here; relax and read go on to S_DECIDE for the registered store data
        unique case (op_q)
          OP_WR_EDGE: begin
            edge_we = vok_q && slot_ok_q;
            state_d = S_IDLE;
          end
          OP_WR_DEGREE: begin
            deg_we  = vok_q;
            state_d = S_IDLE;
          end
          default: begin
            state_d = S_DECIDE;
          end
        endcase
      end
      S_DECIDE: begin
        done_d = 1'b1;
        if (op_q == OP_RD_DIST) begin
          mdist_d = OUT_DIST_W'(vok_q ? dist_rd_q : DIST_INF);
          state_d = S_IDLE;
        end else if (!vok_q || !(tent_q < dist_rd_q)) begin
          state_d = S_IDLE;
        end else begin
          dist_we = 1'b1;
          if (deg_rd_q == '0) begin
            impr_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            // first edge read is launched at this edge
            done_d   = 1'b0;
            rd_idx_d = DGW'(1);
            state_d  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        done_d     = 1'b1;
        is_msg_d   = 1'b1;
        impr_d     = 1'b1;
        mvtx_d     = edge_rd_q[EW-1 -: VTX_W];
        mdist_d    = OUT_DIST_W'(sat_sum);
        last_d     = emit_last;
        rd_idx_d   = rd_idx_q + DGW'(1);
        emit_idx_d = emit_idx_q + DGW'(1);
        if (emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Walk counters and result payload
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    emit_idx_q <= emit_idx_d;
    is_msg_q   <= is_msg_d;
    impr_q     <= impr_d;
    mvtx_q     <= mvtx_d;
    mdist_q    <= mdist_d;
    last_q     <= last_d;
  end

  assign done_o             = done_q;
  assign is_message_o       = is_msg_q;
  assign improved_o         = impr_q;
  assign message_vertex_o   = mvtx_q;
  assign message_distance_o = mdist_q;
  assign last_o             = last_q;

`ifndef SYNTHESIS
  // a message always belongs to an improving relax
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_message_o |-> improved_o)
    else $error("message without improvement");

  // more results are still to come while the request is not finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !last_o |-> busy)
    else $error("non-final result while idle");

  // no result in the cycle right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o)
    else $error("result right after accept");
`endif

endmodule : sssp_relaxation_engine

`default_nettype wire
